// ===== rtl/ppwm_pkg.sv =====
// ----------------------------------------------------------------------------
// ppwm_pkg: shared types and constants for the polynomial window mask
// Field widths, Q.16 arithmetic widths, register indexes and queue items.
// ----------------------------------------------------------------------------
package ppwm_pkg;

  // Field and register widths
  localparam int PIX_W = 16;
  localparam int DIM_W = 12;
  localparam int POS_W = 11;
  localparam int MU_W  = 4;
  localparam int IDX_W = 2;

  // Largest frame dimension; wider settings are clamped to it
  localparam int MAX_DIMENSION = 2048;

  // Q.16 arithmetic
  localparam int FRAC_W = 16;
  localparam int R_W    = 18;  // signed ratio / power term, range +-1.0
  localparam int F_W    = 18;  // unsigned window factor, range 0..2.0
  localparam int M_W    = 19;  // unsigned separable product, range 0..4.0
  localparam int MUL_W  = 20;  // signed multiplier operand
  localparam int PROD_W = 2 * MUL_W;
  localparam int Y_W    = PROD_W - FRAC_W;
  localparam int DIV_STEPS = FRAC_W;
  localparam int CNT_W  = $clog2(DIV_STEPS);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Register indexes
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
  localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
  localparam logic [IDX_W-1:0] REG_WINDOW_EXPONENT = 2'd2;

  // Register reset values
  localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST     = 12'd512;
  localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST    = 12'd512;
  localparam logic [MU_W-1:0]  WINDOW_EXPONENT_RST = 4'd2;

  typedef logic signed [PIX_W-1:0] pix_t;
  typedef logic [POS_W-1:0]        pos_t;
  typedef logic [DIM_W-1:0]        dim_t;
  typedef logic [MU_W-1:0]         mu_t;

  // One classified pixel on its way to the back end
  typedef struct packed {
    pix_t pixel;
    pos_t col;
    pos_t row;
    pos_t cx;
    pos_t cy;
    mu_t  mu;
    logic frame_end;
  } entry_t;

  // Write side of the queue
  typedef struct packed {
    logic   push;
    entry_t entry;
  } q_wr_t;

  // Read side of the queue
  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_rd_t;

  // Clamp a dimension setting to the largest supported frame size
  function automatic dim_t clamp_dim(dim_t v);
    dim_t lim;
    lim = DIM_W'(MAX_DIMENSION);
    return (v > lim) ? lim : v;
  endfunction

endpackage

// ===== rtl/ppwm_in_if.sv =====
// ----------------------------------------------------------------------------
// ppwm_in_if: pixel input channel
// Valid/ready channel that carries one raw pixel per item.
// ----------------------------------------------------------------------------
interface ppwm_in_if;
  logic          valid;
  logic          ready;
  ppwm_pkg::pix_t pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink   (input valid, input pixel_in, output ready);
endinterface

// ===== rtl/ppwm_out_if.sv =====
// ----------------------------------------------------------------------------
// ppwm_out_if: masked pixel output channel
// Valid/ready channel that carries one masked pixel and its frame flag.
// ----------------------------------------------------------------------------
interface ppwm_out_if;
  logic          valid;
  logic          ready;
  ppwm_pkg::pix_t pixel_out;
  logic          frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

// ===== rtl/ppwm_cfg_if.sv =====
// ----------------------------------------------------------------------------
// ppwm_cfg_if: configuration write channel
// Valid/ready channel that carries a register index and its write data.
// ----------------------------------------------------------------------------
interface ppwm_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ppwm_pkg::IDX_W-1:0]    index;
  logic [ppwm_pkg::DIM_W-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/ppwm_front.sv =====
// ----------------------------------------------------------------------------
// ppwm_front: configuration registers and pixel classification
// Holds the frame settings, tracks the raster position, flags the last
// pixel of a frame and pushes each item with its window setup to the queue.
// ----------------------------------------------------------------------------
module ppwm_front (
  input  logic              clk,
  input  logic              rst,
  ppwm_cfg_if.sink          cfg,
  ppwm_in_if.sink           pixels,
  input  logic              queue_full,
  output ppwm_pkg::q_wr_t   wr
);

  ppwm_pkg::dim_t image_width;
  ppwm_pkg::dim_t image_height;
  ppwm_pkg::mu_t  window_exponent;
  ppwm_pkg::pos_t col;
  ppwm_pkg::pos_t row;

  ppwm_pkg::dim_t w_eff;
  ppwm_pkg::dim_t h_eff;
  ppwm_pkg::dim_t col_inc;
  ppwm_pkg::dim_t row_inc;
  logic           row_end;
  logic           last_row;
  logic           accept;

  // Register writes are always taken
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= ppwm_pkg::IMAGE_WIDTH_RST;
      image_height    <= ppwm_pkg::IMAGE_HEIGHT_RST;
      window_exponent <= ppwm_pkg::WINDOW_EXPONENT_RST;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        ppwm_pkg::REG_IMAGE_WIDTH:     image_width     <= cfg.data;
        ppwm_pkg::REG_IMAGE_HEIGHT:    image_height    <= cfg.data;
        ppwm_pkg::REG_WINDOW_EXPONENT: window_exponent <= cfg.data[ppwm_pkg::MU_W-1:0];
        default: ;
      endcase
    end
  end

  // Classify the position of the current item
  assign w_eff    = ppwm_pkg::clamp_dim(image_width);
  assign h_eff    = ppwm_pkg::clamp_dim(image_height);
  assign col_inc  = {1'b0, col} + 1'b1;
  assign row_inc  = {1'b0, row} + 1'b1;
  assign row_end  = col_inc >= w_eff;
  assign last_row = row_inc >= h_eff;

  // Take an item whenever the queue has room
  assign pixels.ready = !queue_full;
  assign accept       = pixels.valid && !queue_full;

  always_comb begin
    wr.push            = accept;
    wr.entry.pixel     = pixels.pixel_in;
    wr.entry.col       = col;
    wr.entry.row       = row;
    wr.entry.cx        = w_eff[ppwm_pkg::DIM_W-1:1];
    wr.entry.cy        = h_eff[ppwm_pkg::DIM_W-1:1];
    wr.entry.mu        = window_exponent;
    wr.entry.frame_end = row_end && last_row;
  end

  // Advance the raster position, wrap at row and frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (row_end) begin
        col <= '0;
        row <= last_row ? '0 : row_inc[ppwm_pkg::POS_W-1:0];
      end else begin
        col <= col_inc[ppwm_pkg::POS_W-1:0];
      end
    end
  end

`ifndef SYNTHESIS
  a_frame_wrap: assert property (@(posedge clk) disable iff (rst)
    accept && wr.entry.frame_end |=> (col == '0) && (row == '0))
    else $error("raster position did not wrap after the last pixel of a frame");
`endif

endmodule

// ===== rtl/ppwm_queue.sv =====
// ----------------------------------------------------------------------------
// ppwm_queue: short item queue between front and back
// Small FIFO of classified items so that each side stalls on its own.
// ----------------------------------------------------------------------------
module ppwm_queue (
  input  logic              clk,
  input  logic              rst,
  input  ppwm_pkg::q_wr_t   wr,
  input  logic              pop,
  output ppwm_pkg::q_rd_t   rd,
  output logic              full
);

  ppwm_pkg::entry_t            mem [ppwm_pkg::QUEUE_DEPTH];
  logic [ppwm_pkg::QPTR_W-1:0] wr_ptr;
  logic [ppwm_pkg::QPTR_W-1:0] rd_ptr;
  logic [ppwm_pkg::QCNT_W-1:0] count;
  logic                        do_pop;

  localparam logic [ppwm_pkg::QPTR_W-1:0] LAST_PTR =
    ppwm_pkg::QPTR_W'(ppwm_pkg::QUEUE_DEPTH - 1);

  assign full     = count == ppwm_pkg::QCNT_W'(ppwm_pkg::QUEUE_DEPTH);
  assign rd.valid = count != '0;
  assign rd.entry = mem[rd_ptr];
  assign do_pop   = pop && rd.valid;

  // Store pushed items
  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem[wr_ptr] <= wr.entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr.push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (wr.push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!wr.push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    wr.push |-> !full)
    else $error("item pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> rd.valid)
    else $error("item popped from an empty queue");
`endif

endmodule

// ===== rtl/ppwm_back.sv =====
// ----------------------------------------------------------------------------
// ppwm_back: window evaluation and pixel scaling
// Sequencer around one restoring divider and one shared 20x20 multiplier:
// column and row ratios, their powers, the separable product, the scaled
// and saturated pixel, then an output register toward the sink.
// ----------------------------------------------------------------------------
module ppwm_back (
  input  logic              clk,
  input  logic              rst,
  input  ppwm_pkg::q_rd_t   rd,
  output logic              pop,
  ppwm_out_if.source        masked
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DIV_INIT = 3'd1;
  localparam logic [2:0] S_DIV      = 3'd2;
  localparam logic [2:0] S_DIV_DONE = 3'd3;
  localparam logic [2:0] S_POW      = 3'd4;
  localparam logic [2:0] S_MASK     = 3'd5;
  localparam logic [2:0] S_SCALE    = 3'd6;

  localparam int R_W   = ppwm_pkg::R_W;
  localparam int F_W   = ppwm_pkg::F_W;
  localparam int M_W   = ppwm_pkg::M_W;
  localparam int MUL_W = ppwm_pkg::MUL_W;
  localparam int POS_W = ppwm_pkg::POS_W;
  localparam int FRAC_W = ppwm_pkg::FRAC_W;

  localparam logic signed [R_W-1:0] ONE_R = R_W'(1 << FRAC_W);
  localparam logic [ppwm_pkg::CNT_W-1:0] LAST_STEP =
    ppwm_pkg::CNT_W'(ppwm_pkg::DIV_STEPS - 1);
  localparam logic signed [ppwm_pkg::Y_W-1:0] Y_MAX = ppwm_pkg::Y_W'(32767);
  localparam logic signed [ppwm_pkg::Y_W-1:0] Y_MIN = -ppwm_pkg::Y_W'(32768);

  // Control
  logic [2:0]                  state;
  logic                        axis_y;
  logic [ppwm_pkg::CNT_W-1:0]  cnt;
  ppwm_pkg::mu_t               k;
  logic                        out_valid;

  // Datapath
  ppwm_pkg::entry_t            cur;
  logic [POS_W:0]              rem;
  logic [FRAC_W-1:0]           q;
  logic                        neg;
  logic                        sat;
  logic                        zero;
  logic signed [R_W-1:0]       rx;
  logic signed [R_W-1:0]       ry;
  logic signed [R_W-1:0]       t;
  logic [F_W-1:0]              fx;
  logic [F_W-1:0]              fy;
  logic [M_W-1:0]              m;
  ppwm_pkg::pix_t              pixel_out;
  logic                        frame_end;

  // Combinational helpers
  ppwm_pkg::pos_t              pos_sel;
  ppwm_pkg::pos_t              c_sel;
  logic signed [POS_W:0]       d;
  ppwm_pkg::pos_t              mag;
  logic [POS_W:0]              rem2;
  logic                        ge;
  logic [FRAC_W:0]             rmag;
  logic signed [R_W-1:0]       r_new;
  logic signed [R_W-1:0]       r_sel;
  logic signed [R_W:0]         f_full;
  logic signed [MUL_W-1:0]     ma;
  logic signed [MUL_W-1:0]     mb;
  logic signed [ppwm_pkg::PROD_W-1:0] prod;
  logic signed [ppwm_pkg::Y_W-1:0]    y;
  ppwm_pkg::pix_t              y_sat;
  logic                        pow_done;
  logic                        out_free;
  logic                        load_out;

  // Distance from the centre for the axis in work
  assign pos_sel = axis_y ? cur.row : cur.col;
  assign c_sel   = axis_y ? cur.cy : cur.cx;
  assign d       = $signed({1'b0, pos_sel}) - $signed({1'b0, c_sel});
  assign mag     = d[POS_W] ? POS_W'(-d) : d[POS_W-1:0];

  // One restoring step of the ratio division
  assign rem2 = {rem[POS_W-1:0], 1'b0};
  assign ge   = rem2 >= {1'b0, c_sel};

  // Signed, saturated ratio from the finished quotient
  always_comb begin
    if (zero) begin
      rmag = '0;
    end else if (sat) begin
      rmag = (FRAC_W + 1)'(1 << FRAC_W);
    end else begin
      rmag = {1'b0, q};
    end
    r_new = neg ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
  end

  assign r_sel    = axis_y ? ry : rx;
  assign pow_done = k == cur.mu;
  assign f_full   = $signed({ONE_R[R_W-1], ONE_R}) - $signed({t[R_W-1], t});

  // Shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      S_POW: begin
        ma = MUL_W'(t);
        mb = MUL_W'(r_sel);
      end
      S_MASK: begin
        ma = $signed({{(MUL_W - F_W){1'b0}}, fx});
        mb = $signed({{(MUL_W - F_W){1'b0}}, fy});
      end
      S_SCALE: begin
        ma = MUL_W'(cur.pixel);
        mb = $signed({{(MUL_W - M_W){1'b0}}, m});
      end
      default: ;
    endcase
  end

  assign prod = ma * mb;
  assign y    = prod[ppwm_pkg::PROD_W-1:FRAC_W];

  // Saturate the scaled pixel to 16 bits
  always_comb begin
    if (y > Y_MAX) begin
      y_sat = 16'sh7fff;
    end else if (y < Y_MIN) begin
      y_sat = -16'sh8000;
    end else begin
      y_sat = y[ppwm_pkg::PIX_W-1:0];
    end
  end

  assign pop      = (state == S_IDLE) && rd.valid;
  assign out_free = !out_valid || masked.ready;
  assign load_out = (state == S_SCALE) && out_free;

  // Sequencer and output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      axis_y    <= 1'b0;
      cnt       <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      // Load a new item, or drop the held one once taken
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (masked.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (rd.valid) begin
            axis_y <= 1'b0;
            state  <= S_DIV_INIT;
          end
        end
        S_DIV_INIT: begin
          cnt   <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == LAST_STEP) begin
            state <= S_DIV_DONE;
          end
        end
        S_DIV_DONE: begin
          if (!axis_y) begin
            axis_y <= 1'b1;
            state  <= S_DIV_INIT;
          end else begin
            axis_y <= 1'b0;
            k      <= '0;
            state  <= S_POW;
          end
        end
        S_POW: begin
          if (pow_done) begin
            k <= '0;
            if (!axis_y) begin
              axis_y <= 1'b1;
            end else begin
              state <= S_MASK;
            end
          end else begin
            k <= k + 1'b1;
          end
        end
        S_MASK: begin
          state <= S_SCALE;
        end
        S_SCALE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= rd.entry;
    end
    if (state == S_DIV_INIT) begin
      rem  <= {1'b0, mag};
      q    <= '0;
      neg  <= d[POS_W];
      sat  <= mag >= c_sel;
      zero <= c_sel == '0;
    end
    if (state == S_DIV) begin
      rem <= ge ? rem2 - {1'b0, c_sel} : rem2;
      q   <= {q[FRAC_W-2:0], ge};
    end
    if (state == S_DIV_DONE) begin
      if (axis_y) begin
        ry <= r_new;
      end else begin
        rx <= r_new;
      end
      t <= ONE_R;
    end
    if (state == S_POW) begin
      if (pow_done) begin
        if (axis_y) begin
          fy <= f_full[F_W-1:0];
        end else begin
          fx <= f_full[F_W-1:0];
        end
        t <= ONE_R;
      end else begin
        t <= prod[FRAC_W + R_W - 1:FRAC_W];
      end
    end
    if (state == S_MASK) begin
      m <= prod[FRAC_W + M_W - 1:FRAC_W];
    end
    if (load_out) begin
      pixel_out <= y_sat;
      frame_end <= cur.frame_end;
    end
  end

  assign masked.valid     = out_valid;
  assign masked.pixel_out = pixel_out;
  assign masked.frame_end = frame_end;

`ifndef SYNTHESIS
  a_div_runs: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) && (cnt != LAST_STEP) |=> state == S_DIV)
    else $error("division left before its last step");
  a_ratio_range: assert property (@(posedge clk) disable iff (rst)
    state == S_POW |-> (rx <= ONE_R) && (rx >= -ONE_R) && (ry <= ONE_R) && (ry >= -ONE_R))
    else $error("ratio outside of +-1.0");
  a_pop_starts: assert property (@(posedge clk) disable iff (rst)
    pop |=> (state == S_DIV_INIT) && !axis_y)
    else $error("popped item did not start on the column axis");
`endif

endmodule

// ===== rtl/pixel_polynomial_window_mask.sv =====
// ----------------------------------------------------------------------------
// pixel_polynomial_window_mask: separable polynomial window on a pixel stream
// Scales each raster-order pixel by fx*fy, fx = 1 - ((col-cx)/cx)^mu in Q.16,
// and saturates the result to signed 16 bits.
// ----------------------------------------------------------------------------
//
//   channel  role    payload                  handshake
//   -------  ------  -----------------------  -----------
//   cfg      sink    index, data              valid/ready
//   pixels   sink    pixel_in                 valid/ready
//   masked   source  pixel_out, frame_end     valid/ready
//
// The back end works on one item at a time: two 16-step
// restoring divisions, window_exponent+1 passes of the shared multiplier per
// axis, one product and one scaling step. The queue holds up to two
// queued items, so pixels are taken while an item is in work.
// Reset (rst, synchronous) restores 512 x 512 and exponent 2, and clears the
// raster position, the queue and the output register.
// A stalled output holds its item; the back end waits in the scaling step.
// ----------------------------------------------------------------------------
module pixel_polynomial_window_mask (
  input  logic        clk,
  input  logic        rst,
  ppwm_cfg_if.sink    cfg,
  ppwm_in_if.sink     pixels,
  ppwm_out_if.source  masked
);

  ppwm_pkg::q_wr_t wr;
  ppwm_pkg::q_rd_t rd;
  logic            queue_full;
  logic            pop;

  ppwm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pixels     (pixels),
    .queue_full (queue_full),
    .wr         (wr)
  );

  ppwm_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .pop  (pop),
    .rd   (rd),
    .full (queue_full)
  );

  ppwm_back u_back (
    .clk    (clk),
    .rst    (rst),
    .rd     (rd),
    .pop    (pop),
    .masked (masked)
  );

endmodule

// ===== tb/tb_pixel_polynomial_window_mask.sv =====
// ----------------------------------------------------------------------------
// tb_pixel_polynomial_window_mask: self-checking bench for the window mask
// Walks a short table of directed pixels and register writes, then random
// phases of settings and pixel bursts. Every masked item is compared field by
// field with its table entry or a Q.16 model; both channels stall at random.
// ----------------------------------------------------------------------------
module tb_pixel_polynomial_window_mask;
  import ppwm_pkg::*;

  localparam int  CLK_HALF      = 5;
  localparam int  RESET_CYCLES  = 4;
  localparam int  RANDOM_ITEMS  = 1680;
  localparam int  HOLD_PHASE    = 3;
  localparam int  HOLD_CYCLES   = 500;
  localparam int  SETTLE_CYCLES = 150;
  localparam int  CYCLE_LIMIT   = 1500000;
  localparam int  REPORT_LIMIT  = 10;
  localparam longint ONE_Q16    = 65536;

  // Index with no register behind it; writes to it must change nothing
  localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef enum logic {STEP_WRITE, STEP_PIXEL} step_kind_t;

  typedef struct {
    step_kind_t       kind;
    logic [IDX_W-1:0] index;
    dim_t             data;
    pix_t             pixel;
    bit               known;
    pix_t             want_pixel;
    bit               want_end;
  } step_t;

  typedef struct {
    pix_t pixel;
    bit   frame_end;
  } masked_t;

  logic clk;
  logic rst;

  ppwm_cfg_if cfg_ch ();
  ppwm_in_if  pix_ch ();
  ppwm_out_if mask_ch ();

  pixel_polynomial_window_mask dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .pixels (pix_ch),
    .masked (mask_ch)
  );

  // Model state: register copies and raster position
  dim_t   reg_width  = IMAGE_WIDTH_RST;
  dim_t   reg_height = IMAGE_HEIGHT_RST;
  mu_t    reg_expo   = WINDOW_EXPONENT_RST;
  longint pos_col    = 0;
  longint pos_row    = 0;

  masked_t pending_masked[$];
  int      mismatch_count = 0;
  int      cycle_count    = 0;
  bit      hold_request   = 1'b0;

  // Directed table: reset window, clamps, exponent zero, positions past the
  // frame end, saturation both ways, one-pixel rows and the unused index
  step_t script [28] = '{
    '{STEP_PIXEL, REG_IMAGE_WIDTH,     12'd0,    16'h7FFF, 1'b1, 16'h0000, 1'b0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,     12'd0,    16'h8000, 1'b0, 16'h0000, 1'b0},
    '{STEP_WRITE, REG_IMAGE_WIDTH,     12'd4095, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{STEP_WRITE, REG_IMAGE_HEIGHT,    12'd1,    16'h0000, 1'b0, 16'h0000, 1'b0},
    '{STEP_WRITE, REG_WINDOW_EXPONENT, 12'd0,    16'h0000, 1'b0, 16'h0000, 1'b0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,     12'd0,    16'h7FFF, 1'b1, 16'h0000, 1'b0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,     12'd0,    16'h8000, 1'b1, 16'h0000, 1'b0},
    '{STEP_WRITE, REG_IMAGE_WIDTH,     12'd2,    16'h0000, 1'b0, 16'h0000, 1'b0},
    '{STEP_WRITE, REG_IMAGE_HEIGHT,    12'd2,    16'h0000, 1'b0, 16'h0000, 1'b0},
    '{STEP_WRITE, REG_WINDOW_EXPONENT, 12'd1,    16'h0000, 1'b0, 16'h0000, 1'b0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,     12'd0,    16'h7FFF, 1'b1, 16'h0000, 1'b0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,     12'd0,    16'h7FFF, 1'b1, 16'h7FFF, 1'b0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,     12'd0,    16'h8000, 1'b1, 16'h8000, 1'b1},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,     12'd0,    16'h8000, 1'b1, 16'h8000, 1'b0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,     12'd0,    16'h0001, 1'b1, 16'h0002, 1'b0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,     12'd0,    16'hFFFF, 1'b1, 16'hFFFE, 1'b0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,     12'd0,    16'h0000, 1'b1, 16'h0000, 1'b1},
    '{STEP_WRITE, REG_IMAGE_WIDTH,     12'd1,    16'h0000, 1'b0, 16'h0000, 1'b0},
    '{STEP_WRITE, REG_IMAGE_HEIGHT,    12'd2048, 16'h0000, 1'b0, 16'h0000, 1'b0},
    '{STEP_WRITE, REG_WINDOW_EXPONENT, 12'hFFF,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{STEP_WRITE, REG_UNUSED,          12'hFFF,  16'h0000, 1'b0, 16'h0000, 1'b0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,     12'd0,    16'h7FFF, 1'b1, 16'h7FFF, 1'b0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,     12'd0,    16'h5555, 1'b0, 16'h0000, 1'b0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,     12'd0,    16'hAAAA, 1'b0, 16'h0000, 1'b0},
    '{STEP_WRITE, REG_IMAGE_WIDTH,     12'd0,    16'h0000, 1'b0, 16'h0000, 1'b0},
    '{STEP_WRITE, REG_WINDOW_EXPONENT, 12'd8,    16'h0000, 1'b0, 16'h0000, 1'b0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,     12'd0,    16'h1234, 1'b0, 16'h0000, 1'b0},
    '{STEP_PIXEL, REG_IMAGE_WIDTH,     12'd0,    16'hEDCB, 1'b0, 16'h0000, 1'b0}
  };

  // Clock
  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // One axis of the window: 1.0 - (clamped distance ratio)^mu in Q.16
  function automatic longint axis_weight(longint pos, longint dim, int unsigned mu);
    longint centre;
    longint ratio;
    longint term;
    centre = dim / 2;
    ratio  = 0;
    term   = ONE_Q16;
    if (centre != 0) begin
      ratio = ((pos - centre) * ONE_Q16) / centre;
      if (ratio > ONE_Q16) ratio = ONE_Q16;
      if (ratio < -ONE_Q16) ratio = -ONE_Q16;
    end
    for (int k = 0; k < mu; k++) begin
      term = (term * ratio) >>> 16;
    end
    return ONE_Q16 - term;
  endfunction

  // Mask one pixel at the current raster position, then advance the position
  function automatic masked_t mask_pixel(pix_t p);
    longint  w;
    longint  h;
    longint  weight;
    longint  scaled;
    bit      row_end;
    bit      last_row;
    masked_t res;
    w = (reg_width > MAX_DIMENSION) ? MAX_DIMENSION : reg_width;
    h = (reg_height > MAX_DIMENSION) ? MAX_DIMENSION : reg_height;
    weight = (axis_weight(pos_col, w, reg_expo) * axis_weight(pos_row, h, reg_expo)) >>> 16;
    scaled = (longint'(p) * weight) >>> 16;
    if (scaled > 32767) scaled = 32767;
    if (scaled < -32768) scaled = -32768;
    row_end  = (pos_col + 1) >= w;
    last_row = (pos_row + 1) >= h;
    res.pixel     = pix_t'(scaled);
    res.frame_end = row_end && last_row;
    if (row_end) begin
      pos_col = 0;
      pos_row = last_row ? 0 : pos_row + 1;
    end else begin
      pos_col = pos_col + 1;
    end
    return res;
  endfunction

  // Mostly back-to-back, sometimes short gaps, rarely long ones
  function automatic int pick_gap();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) return 0;
    if (r < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Mostly small frames, with the odd degenerate or oversized dimension
  function automatic dim_t pick_dim();
    case ($urandom_range(0, 15))
      0:       return dim_t'($urandom_range(0, 1));
      1:       return dim_t'($urandom_range(2000, 4095));
      2:       return dim_t'($urandom_range(41, 300));
      default: return dim_t'($urandom_range(2, 40));
    endcase
  endfunction

  task automatic note_mismatch(string what);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("ERROR cycle %0d: %s", cycle_count, what);
    end
  endtask

  // Offer one pixel after a gap, hold it until taken, and queue its result
  task automatic send_pixel(pix_t v, int gap, bit known, pix_t want_pixel, bit want_end);
    masked_t res;
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid    <= 1'b1;
    pix_ch.pixel_in <= v;
    do @(posedge clk); while (!pix_ch.ready);
    res = mask_pixel(v);
    if (known) begin
      res.pixel     = want_pixel;
      res.frame_end = want_end;
    end
    pending_masked.push_back(res);
  endtask

  // Drain all results, then write one register
  task automatic write_register(logic [IDX_W-1:0] idx, dim_t value);
    pix_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_masked.size() != 0);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      REG_IMAGE_WIDTH:     reg_width  = value;
      REG_IMAGE_HEIGHT:    reg_height = value;
      REG_WINDOW_EXPONENT: reg_expo   = value[MU_W-1:0];
      default: ;
    endcase
  endtask

  // Stimulus
  initial begin
    int   sent;
    int   phase;
    int   burst;
    bit   steady;
    bit   wrote;
    pix_t v;
    rst             = 1'b1;
    pix_ch.valid    = 1'b0;
    pix_ch.pixel_in = '0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = REG_IMAGE_WIDTH;
    cfg_ch.data     = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (script[i]) begin
      if (script[i].kind == STEP_WRITE) begin
        write_register(script[i].index, script[i].data);
      end else begin
        send_pixel(script[i].pixel, pick_gap(), script[i].known,
                   script[i].want_pixel, script[i].want_end);
      end
    end

    // Random phases: new settings, then a burst of pixels
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      wrote = 1'b0;
      if ($urandom_range(0, 1) == 1) begin
        write_register(REG_IMAGE_WIDTH, pick_dim());
        wrote = 1'b1;
      end
      if ($urandom_range(0, 1) == 1) begin
        write_register(REG_IMAGE_HEIGHT, pick_dim());
        wrote = 1'b1;
      end
      if (!wrote || $urandom_range(0, 1) == 1) begin
        case ($urandom_range(0, 9))
          0:       v = 16'(0);
          1:       v = 16'($urandom_range(9, 15));
          default: v = 16'($urandom_range(1, 8));
        endcase
        write_register(REG_WINDOW_EXPONENT, {8'($urandom()), v[MU_W-1:0]});
      end
      if ($urandom_range(0, 19) == 0) begin
        write_register(REG_UNUSED, dim_t'($urandom()));
      end

      burst  = (phase == HOLD_PHASE) ? 60 : $urandom_range(4, 60);
      steady = (phase == HOLD_PHASE) || ($urandom_range(0, 3) == 0);
      if (phase == HOLD_PHASE) hold_request = 1'b1;

      repeat (burst) begin
        case ($urandom_range(0, 7))
          0:       v = 16'h7FFF;
          1:       v = 16'h8000;
          2:       v = pix_t'(int'($urandom_range(0, 15)) - 8);
          default: v = pix_t'($urandom());
        endcase
        send_pixel(v, steady ? 0 : pick_gap(), 1'b0, '0, 1'b0);
        sent++;
      end
      phase++;
    end

    // Drain, let any stray result show up, then report
    pix_ch.valid <= 1'b0;
    while (pending_masked.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_masked.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Output back-pressure: random stalls, plus one long hold on request
  initial begin
    mask_ch.ready = 1'b0;
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        mask_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      case ($urandom_range(0, 31)) inside
        [0:19]: begin
          mask_ch.ready <= 1'b1;
          repeat ($urandom_range(1, 20)) @(posedge clk);
        end
        [20:29]: begin
          mask_ch.ready <= 1'b0;
          repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        default: begin
          mask_ch.ready <= 1'b0;
          repeat ($urandom_range(10, 40)) @(posedge clk);
        end
      endcase
    end
  end

  // Compare each accepted item with the oldest expectation
  always @(posedge clk) begin
    masked_t want;
    if (!rst && mask_ch.valid && mask_ch.ready) begin
      if (pending_masked.size() == 0) begin
        note_mismatch($sformatf("unexpected item pixel_out=%0d frame_end=%0b",
                                mask_ch.pixel_out, mask_ch.frame_end));
      end else begin
        want = pending_masked.pop_front();
        if (mask_ch.pixel_out !== want.pixel) begin
          note_mismatch($sformatf("pixel_out expected %0d got %0d",
                                  want.pixel, mask_ch.pixel_out));
        end
        if (mask_ch.frame_end !== want.frame_end) begin
          note_mismatch($sformatf("frame_end expected %0b got %0b",
                                  want.frame_end, mask_ch.frame_end));
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

endmodule
